>>> design/csem_pkg.sv
// shared constants, types and register codes for the counting semaphore table
// no dependencies; imported by every other file of the block except csem_ram
package csem_pkg;

  // table geometry
  localparam int NUM_SEMAPHORES = 4;
  localparam int QUEUE_DEPTH    = 16;
  localparam int SEM_W   = (NUM_SEMAPHORES > 1) ? $clog2(NUM_SEMAPHORES) : 1;
  localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
  localparam int QLEN_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int WADDR_W = $clog2(NUM_SEMAPHORES * QUEUE_DEPTH);

  // transaction field widths
  localparam int OP_W     = 1;
  localparam int IDX_W    = 2;
  localparam int TID_W    = 16;
  localparam int PID_W    = 8;
  localparam int WAITER_W = TID_W + PID_W;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // configuration registers
  localparam int CNT_REG_W     = 8;
  localparam int NUM_REG_SETS  = 4;
  localparam int REG_SET_W     = $clog2(NUM_REG_SETS);
  localparam int REG_INIT_BASE = 0;
  localparam int REG_MAX_BASE  = 4;
  localparam int NUM_REGS      = 8;
  localparam int CFG_AW        = $clog2(NUM_REGS * 4);
  localparam int REG_IDX_W     = CFG_AW - 2;
  localparam int CFG_DW        = 32;
  localparam logic [CNT_REG_W-1:0] INIT_RESET = CNT_REG_W'(1);
  localparam logic [CNT_REG_W-1:0] MAX_RESET  = CNT_REG_W'(255);

  typedef enum logic [OP_W-1:0] {
    OP_WAIT   = 1'b0,
    OP_SIGNAL = 1'b1
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_PROCEED  = 2'd0,
    ST_BLOCKED  = 2'd1,
    ST_REJECTED = 2'd2
  } status_e;

  // one entry of the semaphore state memory
  typedef struct packed {
    logic signed [COUNT_W-1:0] count;
    logic [QLEN_W-1:0]         len;
  } sem_entry_t;

  localparam int SEM_ENTRY_W = $bits(sem_entry_t);

  // register file view handed to the controller
  typedef struct packed {
    logic [NUM_REG_SETS-1:0][CNT_REG_W-1:0] init_count;
    logic [NUM_REG_SETS-1:0][CNT_REG_W-1:0] max_count;
    logic                                   reload;
    logic [REG_SET_W-1:0]                   reload_set;
  } cfg_t;

endpackage

>>> design/csem_req_if.sv
// request channel: one semaphore operation per transaction
// depends on csem_pkg
interface csem_req_if;
  import csem_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [IDX_W-1:0]  sem_index;
  logic [TID_W-1:0]  thread_tid;
  logic [PID_W-1:0]  thread_pid;

  modport source (output valid, operation, sem_index, thread_tid, thread_pid, input ready);
  modport sink   (input valid, operation, sem_index, thread_tid, thread_pid, output ready);
endinterface

>>> design/csem_rsp_if.sv
// response channel: one result per request transaction
// depends on csem_pkg
interface csem_rsp_if;
  import csem_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [STATUS_W-1:0]       wait_status;
  logic                      woken_valid;
  logic [TID_W-1:0]          woken_tid;
  logic [PID_W-1:0]          woken_pid;
  logic signed [COUNT_W-1:0] count_after;

  modport source (output valid, wait_status, woken_valid, woken_tid, woken_pid, count_after,
                  input ready);
  modport sink   (input valid, wait_status, woken_valid, woken_tid, woken_pid, count_after,
                  output ready);
endinterface

>>> design/csem_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
module csem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read, read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

>>> design/csem_cfg.sv
// apb-style register file: initial counts and ceilings per register set
// depends on csem_pkg
module csem_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csem_pkg::CFG_AW-1:0]   paddr,
  input  logic [csem_pkg::CFG_DW-1:0]   pwdata,
  output logic [csem_pkg::CFG_DW-1:0]   prdata,
  output logic                          pready,
  output csem_pkg::cfg_t                cfg_o
);
  import csem_pkg::*;

  logic [NUM_REG_SETS-1:0][CNT_REG_W-1:0] init_q;
  logic [NUM_REG_SETS-1:0][CNT_REG_W-1:0] max_q;
  logic [REG_IDX_W-1:0]                   reg_idx;
  logic [REG_SET_W-1:0]                   init_set;
  logic [REG_SET_W-1:0]                   max_set;
  logic                                   wr_en;
  logic                                   is_init;
  logic                                   is_max;

  assign pready   = 1'b1;
  assign reg_idx  = paddr[CFG_AW-1:2];
  assign wr_en    = psel & penable & pwrite;
  assign is_init  = (32'(reg_idx) >= REG_INIT_BASE) && (32'(reg_idx) < REG_MAX_BASE);
  assign is_max   = (32'(reg_idx) >= REG_MAX_BASE) && (32'(reg_idx) < NUM_REGS);
  assign init_set = REG_SET_W'(32'(reg_idx) - REG_INIT_BASE);
  assign max_set  = REG_SET_W'(32'(reg_idx) - REG_MAX_BASE);

  // register write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REG_SETS; i++) begin
        init_q[i] <= INIT_RESET;
        max_q[i]  <= MAX_RESET;
      end
    end else if (wr_en) begin
      if (is_init) begin
        init_q[init_set] <= pwdata[CNT_REG_W-1:0];
      end else if (is_max) begin
        max_q[max_set] <= pwdata[CNT_REG_W-1:0];
      end
    end
  end

  // register read
  always_comb begin
    prdata = '0;
    if (is_init) begin
      prdata = CFG_DW'(init_q[init_set]);
    end else if (is_max) begin
      prdata = CFG_DW'(max_q[max_set]);
    end
  end

  // writing an initial count reloads every semaphore of that set
  assign cfg_o.init_count = init_q;
  assign cfg_o.max_count  = max_q;
  assign cfg_o.reload     = wr_en & is_init;
  assign cfg_o.reload_set = init_set;

endmodule

>>> design/csem_ctrl.sv
// semaphore engine: state and waiter memories with a two-step read-modify-write
// depends on csem_pkg, csem_req_if, csem_rsp_if and csem_ram
module csem_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  csem_pkg::cfg_t cfg_i,
  csem_req_if.sink       req_i,
  csem_rsp_if.source     rsp_o
);
  import csem_pkg::*;

  // held transaction
  logic                busy_q;
  logic [OP_W-1:0]     op_q;
  logic [IDX_W-1:0]    sem_q;
  logic [TID_W-1:0]    tid_q;
  logic [PID_W-1:0]    pid_q;
  logic                in_range_q;

  // per-semaphore flops: state entry valid and queue head
  logic [NUM_SEMAPHORES-1:0] st_valid_q;
  logic [QPTR_W-1:0]         head_q [NUM_SEMAPHORES];

  // result register
  logic                      rsp_valid_q;
  logic [STATUS_W-1:0]       status_q;
  logic                      woken_q;
  logic [TID_W-1:0]          wtid_q;
  logic [PID_W-1:0]          wpid_q;
  logic signed [COUNT_W-1:0] count_q;

  logic                      in_accept;
  logic                      go;
  logic                      in_range_in;
  logic [SEM_W-1:0]          head_sel;
  logic [SEM_W-1:0]          sem_a;
  logic [SEM_W-1:0]          sem_in_a;
  logic [WADDR_W-1:0]        wq_raddr;
  logic [WADDR_W-1:0]        wq_waddr;
  logic [WAITER_W-1:0]       wq_rdata;
  logic [SEM_ENTRY_W-1:0]    st_rdata;
  sem_entry_t                st_rd;
  sem_entry_t                st_new;
  logic [REG_SET_W-1:0]      set_a;

  logic signed [COUNT_W-1:0] cnt_cur;
  logic signed [COUNT_W-1:0] cnt_sig;
  logic signed [COUNT_W-1:0] max_s;
  logic [QLEN_W-1:0]         len_cur;
  logic [QPTR_W-1:0]         head_cur;
  logic [QPTR_W-1:0]         head_new;
  logic [QPTR_W:0]           slot_sum;
  logic [QPTR_W:0]           head_inc;
  logic [QPTR_W-1:0]         slot;
  logic                      enqueue;
  logic                      wake;
  status_e                   status;

  assign in_accept   = req_i.valid & req_i.ready;
  assign req_i.ready = !busy_q;
  assign go          = busy_q & (!rsp_valid_q | rsp_o.ready);
  assign in_range_in = 32'(req_i.sem_index) < NUM_SEMAPHORES;
  assign sem_in_a    = SEM_W'(req_i.sem_index);
  assign sem_a       = SEM_W'(sem_q);
  assign set_a       = REG_SET_W'(sem_q);
  assign head_sel    = busy_q ? sem_a : sem_in_a;
  assign head_cur    = head_q[head_sel];

  // oldest waiter of the addressed semaphore, read at accept
  assign wq_raddr = WADDR_W'(32'(sem_in_a) * QUEUE_DEPTH + 32'(head_cur));

  csem_ram #(
    .WIDTH (SEM_ENTRY_W),
    .DEPTH (NUM_SEMAPHORES)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (go & in_range_q),
    .waddr_i (sem_a),
    .wdata_i (st_new),
    .re_i    (in_accept),
    .raddr_i (sem_in_a),
    .rdata_o (st_rdata)
  );

  csem_ram #(
    .WIDTH (WAITER_W),
    .DEPTH (NUM_SEMAPHORES * QUEUE_DEPTH)
  ) u_waiter_ram (
    .clk_i   (clk_i),
    .we_i    (go & in_range_q & enqueue),
    .waddr_i (wq_waddr),
    .wdata_i ({tid_q, pid_q}),
    .re_i    (in_accept),
    .raddr_i (wq_raddr),
    .rdata_o (wq_rdata)
  );

  // an entry not written since reset or reload reads as the initial state
  assign st_rd   = sem_entry_t'(st_rdata);
  assign cnt_cur = st_valid_q[sem_a] ? st_rd.count
                                     : $signed({1'b0, cfg_i.init_count[set_a]});
  assign len_cur = st_valid_q[sem_a] ? st_rd.len : '0;
  assign max_s   = $signed({1'b0, cfg_i.max_count[set_a]});

  // queue pointer arithmetic, both sums stay below twice the depth
  assign slot_sum = (QPTR_W+1)'(head_cur) + (QPTR_W+1)'(len_cur);
  assign slot     = (32'(slot_sum) >= QUEUE_DEPTH) ? QPTR_W'(32'(slot_sum) - QUEUE_DEPTH)
                                                   : QPTR_W'(slot_sum);
  assign head_inc = (QPTR_W+1)'(head_cur) + (QPTR_W+1)'(1);
  assign wq_waddr = WADDR_W'(32'(sem_a) * QUEUE_DEPTH + 32'(slot));
  assign cnt_sig  = (cnt_cur < max_s) ? cnt_cur + COUNT_W'(1) : cnt_cur;

  // modify step
  always_comb begin
    st_new.count = cnt_cur;
    st_new.len   = len_cur;
    head_new     = head_cur;
    status       = ST_PROCEED;
    enqueue      = 1'b0;
    wake         = 1'b0;
    case (op_e'(op_q))
      OP_WAIT: begin
        if (cnt_cur[COUNT_W-1] || cnt_cur == '0) begin
          if (32'(len_cur) >= QUEUE_DEPTH) begin
            status = ST_REJECTED;
          end else begin
            enqueue      = 1'b1;
            st_new.len   = len_cur + QLEN_W'(1);
            st_new.count = cnt_cur - COUNT_W'(1);
            status       = ST_BLOCKED;
          end
        end else begin
          st_new.count = cnt_cur - COUNT_W'(1);
        end
      end
      OP_SIGNAL: begin
        st_new.count = cnt_sig;
        if ((cnt_sig[COUNT_W-1] || cnt_sig == '0) && len_cur != '0) begin
          wake       = 1'b1;
          st_new.len = len_cur - QLEN_W'(1);
          head_new   = (32'(head_inc) == QUEUE_DEPTH) ? '0 : QPTR_W'(head_inc);
        end
      end
      default: begin
        st_new.count = cnt_cur;
      end
    endcase
  end

  // control: sequencing, valid bits, queue heads and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      rsp_valid_q <= 1'b0;
      st_valid_q  <= '0;
      for (int s = 0; s < NUM_SEMAPHORES; s++) begin
        head_q[s] <= '0;
      end
    end else begin
      // result stays until taken, a new one is loaded by the update step
      rsp_valid_q <= go | (rsp_valid_q & !rsp_o.ready);
      if (in_accept) begin
        busy_q <= 1'b1;
      end
      if (go) begin
        busy_q <= 1'b0;
        if (in_range_q) begin
          st_valid_q[sem_a] <= 1'b1;
          head_q[sem_a]     <= head_new;
        end
      end
      // reload of a register set empties its queues
      if (cfg_i.reload) begin
        for (int s = 0; s < NUM_SEMAPHORES; s++) begin
          if (REG_SET_W'(s) == cfg_i.reload_set) begin
            st_valid_q[s] <= 1'b0;
            head_q[s]     <= '0;
          end
        end
      end
    end
  end

  // payload capture
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q       <= req_i.operation;
      sem_q      <= req_i.sem_index;
      tid_q      <= req_i.thread_tid;
      pid_q      <= req_i.thread_pid;
      in_range_q <= in_range_in;
    end
    if (go) begin
      status_q <= in_range_q ? status : ST_PROCEED;
      woken_q  <= in_range_q & wake;
      wtid_q   <= (in_range_q && wake) ? wq_rdata[WAITER_W-1:PID_W] : '0;
      wpid_q   <= (in_range_q && wake) ? wq_rdata[PID_W-1:0] : '0;
      count_q  <= in_range_q ? st_new.count : '0;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.wait_status = status_q;
  assign rsp_o.woken_valid = woken_q;
  assign rsp_o.woken_tid   = wtid_q;
  assign rsp_o.woken_pid   = wpid_q;
  assign rsp_o.count_after = count_q;

  // an accepted transaction occupies the engine until its result is loaded
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> busy_q)
    else $error("accepted transaction did not occupy the engine");

  // a stalled result keeps the next update step waiting
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && rsp_valid_q && !rsp_o.ready |=> busy_q && rsp_valid_q)
    else $error("update step ran over a stalled result");

  // the update step always presents a result
  a_go_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go |=> rsp_valid_q)
    else $error("update step produced no result");

  // a woken thread means the count is zero or less and no wait status
  a_wake_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && woken_q |->
      (count_q[COUNT_W-1] || count_q == '0) && status_q == ST_PROCEED)
    else $error("wake reported with positive count or wait status");

  // the waiter store is written only for a blocking wait
  a_enqueue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && in_range_q && enqueue |-> status == ST_BLOCKED && 32'(len_cur) < QUEUE_DEPTH)
    else $error("waiter written outside a blocking wait");

endmodule

>>> design/counting_semaphore_table_core.sv
// top level of the counting semaphore table: register file and engine
// depends on csem_pkg, csem_req_if, csem_rsp_if, csem_ram, csem_cfg and csem_ctrl
//
//  channel  | direction | handshake            | payload
//  req_i    | in        | valid/ready          | operation, sem_index, thread_tid, thread_pid
//  rsp_o    | out       | valid/ready          | wait_status, woken_*, count_after
//  apb      | in/out    | psel/penable, pready | paddr, pwdata, prdata
//
// each transaction runs as the state and waiter memory reads issued at accept,
// then the update and write back, which also loads the result register
// req_i.ready is low while a transaction is in the engine; a new one is taken while
// the previous result still waits in the result register
// a result held by rsp_o.ready low stalls the update step of the next transaction
// reset needs no clearing pass: per-semaphore valid bits make state read as the
// initial count with an empty queue until first written
module counting_semaphore_table_core (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  csem_req_if.sink                    req_i,
  csem_rsp_if.source                  rsp_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [csem_pkg::CFG_AW-1:0] paddr,
  input  logic [csem_pkg::CFG_DW-1:0] pwdata,
  output logic [csem_pkg::CFG_DW-1:0] prdata,
  output logic                        pready
);
  import csem_pkg::*;

  cfg_t cfg;

  // configuration registers
  csem_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // semaphore engine with its memories
  csem_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule
